@@ design/lmfs_pkg.sv @@
package lmfs_pkg;

  localparam int MaxDevices = 8;
  localparam int Rows       = 8;
  localparam int StoreDepth = MaxDevices * Rows;
  localparam int AddrW      = $clog2(StoreDepth);

  // Input command codes
  localparam logic [1:0] CMD_CLEAR     = 2'd0;
  localparam logic [1:0] CMD_PIXEL     = 2'd1;
  localparam logic [1:0] CMD_COMMIT    = 2'd2;
  localparam logic [1:0] CMD_INTENSITY = 2'd3;

  // Configuration register indexes
  localparam logic [3:0] CFG_DEVICE_COUNT = 4'd0;
  localparam logic [3:0] CFG_ALT_ORIENT   = 4'd1;

  localparam logic [3:0] INTENSITY_REG = 4'd10;
  localparam logic [3:0] DEV_COUNT_RST = 4'd1;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLEAR,
    OP_PIXEL,
    OP_COMMIT,
    OP_INTENS
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] col;
    logic [2:0] row;
    logic [3:0] level;
  } job_t;

  typedef struct packed {
    logic [3:0] n;    // active modules, 0..8
    logic       alt;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIX_WR,
    ST_CM_RD,
    ST_CM_LAST,
    ST_CM_EMIT,
    ST_INT
  } state_t;

endpackage

@@ design/lmfs_front.sv @@
module lmfs_front
  import lmfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  input  logic [5:0] in_pixel_column,
  input  logic [2:0] in_pixel_row,
  input  logic [3:0] in_intensity_level,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_index,
  input  logic [3:0] cfg_data,
  input  logic       push_ready,
  output logic       push_valid,
  output job_t       push_job,
  output cfg_t       cfg
);

  logic [3:0] dev_count_r;
  logic       alt_r;
  logic [3:0] n_act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_count_r <= DEV_COUNT_RST;
      alt_r       <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_DEVICE_COUNT) begin
        dev_count_r <= cfg_data;
      end else if (cfg_index == CFG_ALT_ORIENT) begin
        alt_r <= cfg_data[0];
      end
    end
  end

  // Saturate the chain length
  assign n_act     = (dev_count_r > 4'(MaxDevices)) ? 4'(MaxDevices) : dev_count_r;
  assign cfg.n     = n_act;
  assign cfg.alt   = alt_r;
  assign cfg_ready = 1'b1;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  // Classify: drop out-of-range pixels and word commands on an empty chain
  always_comb begin
    push_job.col   = in_pixel_column;
    push_job.row   = in_pixel_row;
    push_job.level = in_intensity_level;
    case (in_command)
      CMD_CLEAR:  push_job.op = OP_CLEAR;
      CMD_PIXEL:  push_job.op = ({1'b0, in_pixel_column[5:3]} < n_act) ? OP_PIXEL : OP_NOP;
      CMD_COMMIT: push_job.op = (n_act != 4'd0) ? OP_COMMIT : OP_NOP;
      CMD_INTENSITY: push_job.op = (n_act != 4'd0) ? OP_INTENS : OP_NOP;
      default:    push_job.op = OP_NOP;
    endcase
  end

endmodule

@@ design/lmfs_queue.sv @@
module lmfs_queue
  import lmfs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  job_t       entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_job    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

@@ design/lmfs_back.sv @@
module lmfs_back
  import lmfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_valid,
  output logic       q_ready,
  input  job_t       q_job,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_register_address,
  output logic [7:0] out_data_byte,
  output logic       out_frame_end,
  output logic       out_last
);

  state_t state_r;
  state_t state_nxt;

  logic [7:0]       mem [StoreDepth];
  logic [StoreDepth-1:0] valid_r;
  logic [7:0]       mem_rd_r;
  logic             vbit_r;
  logic [7:0]       rd_byte;

  job_t       job_r;
  logic [2:0] r_r;
  logic [2:0] d_r;
  logic [2:0] f_r;
  logic [2:0] f_d_r;
  logic       rd_live_r;
  logic [7:0] acc_r;

  logic             pop;
  logic             clr;
  logic             wr_en;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]       wr_data;
  logic             slot_free;
  logic             out_load;
  logic             fend;

  logic       out_valid_r;
  logic [3:0] reg_r;
  logic [7:0] data_r;
  logic       fend_r;
  logic       last_r;
  logic [3:0] reg_nxt;
  logic [7:0] data_nxt;
  logic       last_nxt;

  assign slot_free = !out_valid_r || out_ready;
  assign fend      = ({1'b0, d_r} == (cfg.n - 4'd1));
  assign rd_byte   = vbit_r ? mem_rd_r : 8'h00;
  assign pop       = q_ready && q_valid;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_job.op)
            OP_PIXEL:  state_nxt = ST_PIX_WR;
            OP_COMMIT: state_nxt = ST_CM_RD;
            OP_INTENS: state_nxt = ST_INT;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PIX_WR: state_nxt = ST_IDLE;
      ST_CM_RD: begin
        if (!cfg.alt || f_r == 3'd7) begin
          state_nxt = ST_CM_LAST;
        end
      end
      ST_CM_LAST: state_nxt = ST_CM_EMIT;
      ST_CM_EMIT: begin
        if (slot_free) begin
          state_nxt = (fend && r_r == 3'd7) ? ST_IDLE : ST_CM_RD;
        end
      end
      ST_INT: begin
        if (slot_free && fend) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    q_ready  = 1'b0;
    clr      = 1'b0;
    wr_en    = 1'b0;
    out_load = 1'b0;
    rd_addr  = job_r.col;
    reg_nxt  = INTENSITY_REG;
    data_nxt = {4'd0, job_r.level};
    last_nxt = fend;
    case (state_r)
      ST_IDLE: begin
        q_ready = 1'b1;
        clr     = q_valid && (q_job.op == OP_CLEAR);
        rd_addr = q_job.col;
      end
      ST_PIX_WR: wr_en = 1'b1;
      ST_CM_RD:  rd_addr = {d_r, (cfg.alt ? f_r : r_r)};
      ST_CM_EMIT: begin
        out_load = slot_free;
        reg_nxt  = {1'b0, r_r} + 4'd1;
        data_nxt = acc_r;
        last_nxt = fend && (r_r == 3'd7);
      end
      ST_INT: out_load = slot_free;
      default: q_ready = 1'b0;
    endcase
  end

  assign wr_data = rd_byte | (8'd1 << job_r.row);

  // Column store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[job_r.col] <= wr_data;
    end
    mem_rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vbit_r  <= 1'b0;
    end else begin
      if (clr) begin
        valid_r <= '0;
      end else if (wr_en) begin
        valid_r[job_r.col] <= 1'b1;
      end
      vbit_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_live_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_live_r <= (state_r == ST_CM_RD);
    end
  end

  // Job, counters and row assembly
  always_ff @(posedge clk) begin
    f_d_r <= f_r;
    if (pop) begin
      job_r <= q_job;
      r_r   <= 3'd0;
      d_r   <= 3'd0;
      f_r   <= 3'd0;
    end
    if (state_r == ST_CM_RD) begin
      f_r <= f_r + 3'd1;
    end
    if (out_load) begin
      f_r <= 3'd0;
      if (fend) begin
        d_r <= 3'd0;
        r_r <= r_r + 3'd1;
      end else begin
        d_r <= d_r + 3'd1;
      end
    end
    if (rd_live_r) begin
      if (cfg.alt) begin
        acc_r[3'd7 - f_d_r] <= rd_byte[r_r];
      end else begin
        acc_r <= rd_byte;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      reg_r  <= reg_nxt;
      data_r <= data_nxt;
      fend_r <= fend;
      last_r <= last_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_register_address = reg_r;
  assign out_data_byte        = data_r;
  assign out_frame_end        = fend_r;
  assign out_last             = last_r;

  a_last_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CM_LAST |-> rd_live_r && $past(state_r) == ST_CM_RD)
    else $error("row assembly entered without a pending read");

  a_dev_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CM_EMIT || state_r == ST_INT) |-> ({1'b0, d_r} < cfg.n))
    else $error("module counter beyond chain length");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && last_nxt |=> state_r == ST_IDLE)
    else $error("sequencer busy after final word");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !q_ready && $past(pop))
    else $error("pixel write without a popped command");

endmodule

@@ design/led_matrix_frame_scanner.sv @@
// Channel | Handshake              | Payload
// in      | in_valid / in_ready    | command, pixel_column, pixel_row, intensity_level
// out     | out_valid / out_ready  | register_address, data_byte, frame_end, last
// cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data (0 device_count, 1 alt orient)
//
// Clear acts as the back end pops it; set pixel reads, then merges and writes.
// Commit walks ST_CM_RD, ST_CM_LAST and ST_CM_EMIT for each word; when transposed,
// ST_CM_RD repeats: each word needs eight reads of the single store read port.
// Set intensity gives one word a cycle unless output stalls. A two-deep command queue decouples input.
// Reset (rst_n, synchronous) empties the queue and marks every store byte as zero.
// Output stalls hold the word in the output register and stall the sequencer; input
// stalls once the two-deep queue is full.
module led_matrix_frame_scanner
  import lmfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  input  logic [5:0] in_pixel_column,
  input  logic [2:0] in_pixel_row,
  input  logic [3:0] in_intensity_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_register_address,
  output logic [7:0] out_data_byte,
  output logic       out_frame_end,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_index,
  input  logic [3:0] cfg_data
);

  cfg_t cfg;
  job_t push_job;
  job_t pop_job;
  logic push_valid;
  logic push_ready;
  logic pop_valid;
  logic pop_ready;

  // Hold config, classify each word
  lmfs_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_pixel_column    (in_pixel_column),
    .in_pixel_row       (in_pixel_row),
    .in_intensity_level (in_intensity_level),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .push_ready         (push_ready),
    .push_valid         (push_valid),
    .push_job           (push_job),
    .cfg                (cfg)
  );

  lmfs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // Execute commands against the column store, drive the word stream
  lmfs_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg),
    .q_valid              (pop_valid),
    .q_ready              (pop_ready),
    .q_job                (pop_job),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_register_address (out_register_address),
    .out_data_byte        (out_data_byte),
    .out_frame_end        (out_frame_end),
    .out_last             (out_last)
  );

endmodule
